// ===== hdl/cfa_pkg.sv =====
package cfa_pkg;

	localparam int MaxSegments = 64;
	localparam int AddressWidth = 20;
	localparam int OwnerWidth = 10;
	localparam int SizeWidth = 21;
	localparam int IndexWidth = $clog2(MaxSegments);
	localparam int CountWidth = $clog2(MaxSegments + 1);
	localparam int EntryWidth = AddressWidth + SizeWidth + 1 + OwnerWidth;

	localparam logic [SizeWidth-1:0] TotalReset = SizeWidth'(1048576);
	localparam logic [SizeWidth-1:0] SizeCap = SizeWidth'(64'd1 << AddressWidth);

	typedef logic [AddressWidth-1:0] addr_t;
	typedef logic [SizeWidth-1:0] size_t;
	typedef logic [OwnerWidth-1:0] owner_t;
	typedef logic [IndexWidth-1:0] index_t;
	typedef logic [CountWidth-1:0] count_t;

	localparam count_t CountOne = count_t'(1);
	localparam count_t CountFull = count_t'(MaxSegments);

	typedef struct packed {
		logic [AddressWidth-1:0] start;
		logic [SizeWidth-1:0] size;
		logic free;
		logic [OwnerWidth-1:0] owner;
	} entry_t;

	typedef enum logic [1:0] {
		OP_ALLOCATE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_COMPACT = 2'd2,
		OP_INIT = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST = 2'd1,
		FIT_WORST = 2'd2,
		FIT_INVALID = 2'd3
	} strategy_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_HOLE = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL = 3'd3,
		ST_BAD = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_PLACE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_SPLIT_WR,
		S_TAKE_WR,
		S_LEFT_RD,
		S_LEFT_CHK,
		S_RIGHT_RD,
		S_RIGHT_CHK,
		S_MERGE_WR,
		S_PULL_RD,
		S_PULL_WR,
		S_TAIL,
		S_DONE
	} state_t;

endpackage

// ===== hdl/cfa_if.sv =====
interface cfa_in_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [1:0] strategy;
	logic [20:0] request_size;
	logic [9:0] owner_id;
	modport source(output valid, opcode, strategy, request_size, owner_id, input ready);
	modport sink(input valid, opcode, strategy, request_size, owner_id, output ready);
endinterface

interface cfa_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [19:0] address;
	modport source(output valid, status, address, input ready);
	modport sink(input valid, status, address, output ready);
endinterface

// ===== hdl/contiguous_fit_allocator_unit.sv =====
// Channel  | Dir | Payload
// in_ch    | in  | opcode, strategy, request_size, owner_id
// out_ch   | out | status, address
// cfg      | in  | cfg_we, cfg_data (total_size)
// Each table pass reads an entry in one state and checks or writes it in the next. An
// allocate scans up to N entries and may shift up to N-1 more; a full table holds 64
// entries.
// Reset leaves one free 1048576-byte segment; entry 0 is supplied by logic until first
// written, so there is no clearing pass.
// The input is not ready from acceptance until the result beat is taken.
module contiguous_fit_allocator_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [20:0] cfg_data,
	cfa_in_if.sink in_ch,
	cfa_out_if.source out_ch
);
	cfa_pkg::state_t state_q, state_d;
	cfa_pkg::size_t total_q;
	cfa_pkg::count_t count_q;
	cfa_pkg::opcode_t op_q;
	cfa_pkg::strategy_t strat_q;
	cfa_pkg::size_t req_q;
	cfa_pkg::owner_t owner_q;
	cfa_pkg::count_t i_q, j_q, pick_q, used_q;
	logic [1:0] dist_q;
	logic found_q, left_free_q, right_free_q;
	cfa_pkg::entry_t pick_e_q, left_e_q;
	cfa_pkg::size_t right_size_q;
	cfa_pkg::size_t next_q;
	cfa_pkg::status_t status_q;
	cfa_pkg::addr_t addr_q;
	logic e0_valid_q, rd0_q;

	logic we;
	cfa_pkg::index_t waddr, raddr;
	cfa_pkg::entry_t wdata, rdata_raw, rd, merged;
	cfa_pkg::size_t lim;
	logic fit, better, owned, split;
	cfa_pkg::count_t target, pull_src;

	cfa_ram #(.Width(cfa_pkg::EntryWidth), .Depth(cfa_pkg::MaxSegments)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_raw)
	);

	assign in_ch.ready = (state_q == cfa_pkg::S_IDLE);
	assign out_ch.valid = (state_q == cfa_pkg::S_DONE);
	assign out_ch.status = status_q;
	assign out_ch.address = addr_q;

	always_comb begin
		lim = (total_q < cfa_pkg::SizeCap) ? total_q : cfa_pkg::SizeCap;
		rd = rdata_raw;
		if (rd0_q && !e0_valid_q) begin
			rd.start = '0;
			rd.size = cfa_pkg::TotalReset;
			rd.free = 1'b1;
			rd.owner = '0;
		end
		fit = rd.free && (rd.size >= req_q);
		better = !found_q ||
		    (strat_q == cfa_pkg::FIT_BEST && rd.size < pick_e_q.size) ||
		    (strat_q == cfa_pkg::FIT_WORST && rd.size > pick_e_q.size);
		owned = !rd.free && (rd.owner == owner_q);
		split = (pick_e_q.size > req_q);
		target = left_free_q ? pick_q - cfa_pkg::CountOne : pick_q;
		merged = left_free_q ? left_e_q : pick_e_q;
		merged.free = 1'b1;
		merged.size = (left_free_q ? left_e_q.size : '0) + pick_e_q.size +
		    (right_free_q ? right_size_q : '0);
		pull_src = j_q + cfa_pkg::count_t'(dist_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cfa_pkg::S_IDLE: if (in_ch.valid) state_d = cfa_pkg::S_DECODE;
			cfa_pkg::S_DECODE: begin
				if (op_q == cfa_pkg::OP_INIT) state_d = cfa_pkg::S_DONE;
				else if (op_q == cfa_pkg::OP_ALLOCATE &&
				    (req_q == '0 || strat_q == cfa_pkg::FIT_INVALID)) state_d = cfa_pkg::S_DONE;
				else state_d = cfa_pkg::S_SCAN_RD;
			end
			cfa_pkg::S_SCAN_RD: begin
				if (i_q < count_q) state_d = cfa_pkg::S_SCAN_CHK;
				else if (op_q == cfa_pkg::OP_COMPACT) state_d = cfa_pkg::S_TAIL;
				else if (op_q == cfa_pkg::OP_ALLOCATE && found_q) state_d = cfa_pkg::S_PLACE;
				else state_d = cfa_pkg::S_DONE;
			end
			cfa_pkg::S_SCAN_CHK: begin
				state_d = cfa_pkg::S_SCAN_RD;
				if (op_q == cfa_pkg::OP_RELEASE && owned) state_d = cfa_pkg::S_LEFT_RD;
				else if (op_q == cfa_pkg::OP_ALLOCATE && fit && better &&
				    strat_q == cfa_pkg::FIT_FIRST) state_d = cfa_pkg::S_PLACE;
			end
			cfa_pkg::S_PLACE: begin
				if (!split) state_d = cfa_pkg::S_TAKE_WR;
				else if (count_q >= cfa_pkg::CountFull) state_d = cfa_pkg::S_DONE;
				else state_d = cfa_pkg::S_SHIFT_RD;
			end
			cfa_pkg::S_SHIFT_RD: begin
				state_d = (j_q > pick_q + cfa_pkg::CountOne) ? cfa_pkg::S_SHIFT_WR :
				    cfa_pkg::S_SPLIT_WR;
			end
			cfa_pkg::S_SHIFT_WR: state_d = cfa_pkg::S_SHIFT_RD;
			cfa_pkg::S_SPLIT_WR: state_d = cfa_pkg::S_TAKE_WR;
			cfa_pkg::S_TAKE_WR: state_d = cfa_pkg::S_DONE;
			cfa_pkg::S_LEFT_RD: begin
				state_d = (pick_q != '0) ? cfa_pkg::S_LEFT_CHK : cfa_pkg::S_RIGHT_RD;
			end
			cfa_pkg::S_LEFT_CHK: state_d = cfa_pkg::S_RIGHT_RD;
			cfa_pkg::S_RIGHT_RD: begin
				state_d = (pick_q + cfa_pkg::CountOne < count_q) ? cfa_pkg::S_RIGHT_CHK :
				    cfa_pkg::S_MERGE_WR;
			end
			cfa_pkg::S_RIGHT_CHK: state_d = cfa_pkg::S_MERGE_WR;
			cfa_pkg::S_MERGE_WR: begin
				state_d = (left_free_q || right_free_q) ? cfa_pkg::S_PULL_RD : cfa_pkg::S_DONE;
			end
			cfa_pkg::S_PULL_RD: begin
				state_d = (pull_src < count_q) ? cfa_pkg::S_PULL_WR : cfa_pkg::S_DONE;
			end
			cfa_pkg::S_PULL_WR: state_d = cfa_pkg::S_PULL_RD;
			cfa_pkg::S_TAIL: state_d = cfa_pkg::S_DONE;
			cfa_pkg::S_DONE: if (out_ch.ready) state_d = cfa_pkg::S_IDLE;
			default: state_d = cfa_pkg::S_IDLE;
		endcase
	end

	// Reads are registered and land in rd in the next cycle.
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = cfa_pkg::index_t'(i_q);
		case (state_q)
			cfa_pkg::S_DECODE: begin
				if (op_q == cfa_pkg::OP_INIT) begin
					we = 1'b1;
					wdata.size = lim;
					wdata.free = 1'b1;
				end
			end
			cfa_pkg::S_SCAN_CHK: begin
				if (op_q == cfa_pkg::OP_COMPACT && !rd.free) begin
					we = 1'b1;
					waddr = cfa_pkg::index_t'(used_q);
					wdata = rd;
					wdata.start = cfa_pkg::addr_t'(next_q);
				end
			end
			cfa_pkg::S_SHIFT_RD: raddr = cfa_pkg::index_t'(j_q - cfa_pkg::CountOne);
			cfa_pkg::S_SHIFT_WR: begin
				we = 1'b1;
				waddr = cfa_pkg::index_t'(j_q);
				wdata = rd;
			end
			cfa_pkg::S_SPLIT_WR: begin
				we = 1'b1;
				waddr = cfa_pkg::index_t'(pick_q + cfa_pkg::CountOne);
				wdata.start = pick_e_q.start + req_q[cfa_pkg::AddressWidth-1:0];
				wdata.size = pick_e_q.size - req_q;
				wdata.free = 1'b1;
			end
			cfa_pkg::S_TAKE_WR: begin
				we = 1'b1;
				waddr = cfa_pkg::index_t'(pick_q);
				wdata.start = pick_e_q.start;
				wdata.size = req_q;
				wdata.owner = owner_q;
			end
			cfa_pkg::S_LEFT_RD: raddr = cfa_pkg::index_t'(pick_q - cfa_pkg::CountOne);
			cfa_pkg::S_RIGHT_RD: raddr = cfa_pkg::index_t'(pick_q + cfa_pkg::CountOne);
			cfa_pkg::S_MERGE_WR: begin
				we = 1'b1;
				waddr = cfa_pkg::index_t'(target);
				wdata = merged;
			end
			cfa_pkg::S_PULL_RD: raddr = cfa_pkg::index_t'(pull_src);
			cfa_pkg::S_PULL_WR: begin
				we = 1'b1;
				waddr = cfa_pkg::index_t'(j_q);
				wdata = rd;
			end
			cfa_pkg::S_TAIL: begin
				if (used_q < cfa_pkg::CountFull) begin
					we = 1'b1;
					waddr = cfa_pkg::index_t'(used_q);
					wdata.start = cfa_pkg::addr_t'(next_q);
					wdata.size = (next_q < lim) ? lim - next_q : '0;
					wdata.free = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfa_pkg::S_IDLE;
			total_q <= cfa_pkg::TotalReset;
			count_q <= cfa_pkg::CountOne;
			e0_valid_q <= 1'b0;
			rd0_q <= 1'b0;
			op_q <= cfa_pkg::OP_ALLOCATE;
			strat_q <= cfa_pkg::FIT_FIRST;
			req_q <= '0;
			owner_q <= '0;
			i_q <= '0;
			j_q <= '0;
			pick_q <= '0;
			used_q <= '0;
			dist_q <= '0;
			found_q <= 1'b0;
			left_free_q <= 1'b0;
			right_free_q <= 1'b0;
			pick_e_q <= '0;
			left_e_q <= '0;
			right_size_q <= '0;
			next_q <= '0;
			status_q <= cfa_pkg::ST_OK;
			addr_q <= '0;
		end else begin
			state_q <= state_d;
			rd0_q <= (raddr == '0);
			if (cfg_we) total_q <= cfg_data;
			if (we && waddr == '0) e0_valid_q <= 1'b1;
			case (state_q)
				cfa_pkg::S_IDLE: begin
					if (in_ch.valid) begin
						op_q <= cfa_pkg::opcode_t'(in_ch.opcode);
						strat_q <= cfa_pkg::strategy_t'(in_ch.strategy);
						req_q <= in_ch.request_size;
						owner_q <= in_ch.owner_id;
						i_q <= '0;
						used_q <= '0;
						next_q <= '0;
						found_q <= 1'b0;
						left_free_q <= 1'b0;
						right_free_q <= 1'b0;
						status_q <= cfa_pkg::ST_OK;
						addr_q <= '0;
					end
				end
				cfa_pkg::S_DECODE: begin
					if (op_q == cfa_pkg::OP_INIT) begin
						count_q <= cfa_pkg::CountOne;
					end else if (op_q == cfa_pkg::OP_ALLOCATE &&
					    (req_q == '0 || strat_q == cfa_pkg::FIT_INVALID)) begin
						status_q <= cfa_pkg::ST_BAD;
					end
				end
				cfa_pkg::S_SCAN_RD: begin
					if (i_q >= count_q) begin
						if (op_q == cfa_pkg::OP_ALLOCATE && !found_q) begin
							status_q <= cfa_pkg::ST_NO_HOLE;
						end else if (op_q == cfa_pkg::OP_RELEASE) begin
							status_q <= cfa_pkg::ST_NOT_FOUND;
						end
					end
				end
				cfa_pkg::S_SCAN_CHK: begin
					i_q <= i_q + cfa_pkg::CountOne;
					case (op_q)
						cfa_pkg::OP_ALLOCATE: begin
							if (fit && better) begin
								found_q <= 1'b1;
								pick_q <= i_q;
								pick_e_q <= rd;
							end
						end
						cfa_pkg::OP_RELEASE: begin
							if (owned) begin
								pick_q <= i_q;
								pick_e_q <= rd;
							end
						end
						cfa_pkg::OP_COMPACT: begin
							if (!rd.free) begin
								used_q <= used_q + cfa_pkg::CountOne;
								next_q <= next_q + rd.size;
							end
						end
						default: ;
					endcase
				end
				cfa_pkg::S_PLACE: begin
					j_q <= count_q;
					if (split && count_q >= cfa_pkg::CountFull) status_q <= cfa_pkg::ST_FULL;
				end
				cfa_pkg::S_SHIFT_WR: j_q <= j_q - cfa_pkg::CountOne;
				cfa_pkg::S_SPLIT_WR: count_q <= count_q + cfa_pkg::CountOne;
				cfa_pkg::S_TAKE_WR: addr_q <= pick_e_q.start;
				cfa_pkg::S_LEFT_CHK: begin
					left_e_q <= rd;
					left_free_q <= rd.free;
				end
				cfa_pkg::S_RIGHT_CHK: begin
					right_size_q <= rd.size;
					right_free_q <= rd.free;
				end
				cfa_pkg::S_MERGE_WR: begin
					j_q <= target + cfa_pkg::CountOne;
					dist_q <= {1'b0, left_free_q} + {1'b0, right_free_q};
				end
				cfa_pkg::S_PULL_RD: begin
					if (pull_src >= count_q) count_q <= count_q - cfa_pkg::count_t'(dist_q);
				end
				cfa_pkg::S_PULL_WR: j_q <= j_q + cfa_pkg::CountOne;
				cfa_pkg::S_TAIL: begin
					count_q <= (used_q < cfa_pkg::CountFull) ? used_q + cfa_pkg::CountOne :
					    used_q;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== hdl/cfa_ram.sv =====
module cfa_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
